// ----- hdl/cma_pkg.sv -----
// Shared constants for the centered moving average block.
`timescale 1ns / 1ps
package cma_pkg;

  // Default build sizes
  localparam int MAX_RADIUS_DEF  = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  // Radius register
  localparam int              RADIUS_W     = 3;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;

  // Configuration port
  localparam int              CFG_ADDR_W   = 3;
  localparam int              CFG_DATA_W   = 32;
  localparam logic            REG_RADIUS   = 1'b0;  // paddr[2] of the radius register

endpackage

// ----- hdl/cma_store.sv -----
// Sample ring memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cma_store
  import cma_pkg::*;
#(
  parameter int DEPTH  = 2 * MAX_RADIUS_DEF + 1,
  parameter int WIDTH  = SAMPLE_BITS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/cma_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cma_div
  import cma_pkg::*;
#(
  parameter int NUM_W = 22,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;    // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    fits     = (trial >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      num_nxt  = {num_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ----- hdl/centered_moving_average.sv -----
// Top level of the centered moving average filter.
`timescale 1ns / 1ps
// Centered moving average filter.
// Input stream (in_*): one word per sample; in_tdata carries the signed
// sample, in_tlast marks the last sample of a data set. After that sample
// the window is cleared and the next set starts fresh.
// Output stream (out_*): one word per result, the mean of the last 2r+1
// samples rounded half away from zero. The first 2r samples of a set give
// no result. r is the radius register (APB, byte address 0), capped at
// MAX_RADIUS; writing it also clears the window.
// Timing: a sample runs from accept through S_UPD, S_SIGN and the
// radix-2 divider, one quotient bit per cycle over a SUM_W+1 bit dividend,
// to S_OUT and the output register. Samples that give no result go back
// to idle after S_SIGN. in_tready is high only while the sequencer is idle,
// so the next sample is not taken until the last one is through.
// The result sits in an output register: a stalled receiver holds it while
// the next sample is accepted and worked; a new result waits for the slot.
// Reset (rst_n, synchronous) empties the window and the output register
// and sets the radius to 1. The sample memory is not cleared; entries are
// used only once the window has been filled.
module centered_moving_average
  import cma_pkg::*;
#(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                          in_tlast,      // last_in_set
  // output stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,  // [SAMPLE_BITS-1:0] average
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [CFG_DATA_W-1:0]         cfg_prdata,
  output logic                          cfg_pready
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = (LEN_W > RADIUS_W + 1) ? LEN_W : RADIUS_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH + 1) + 1;
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = LEN_W + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,   // waiting for a sample
    S_UPD  = 5'b00010,   // old sample read back, update sum and ring
    S_SIGN = 5'b00100,   // split sign, launch divider
    S_DIV  = 5'b01000,   // divider running
    S_OUT  = 5'b10000    // result waits for the output slot
  } state_t;

  state_t                   state_r, state_nxt;
  logic [RADIUS_W-1:0]      radius_r, radius_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [LEN_W-1:0]         fill_r, fill_nxt;
  logic [PTR_W-1:0]         wp_r, wp_nxt;
  logic [PTR_W-1:0]         slot_r, slot_nxt;
  logic [SAMPLE_BITS-1:0]   sample_r, sample_nxt;
  logic                     last_r, last_nxt;
  logic                     prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]   out_r, out_nxt;

  logic                     in_accept;
  logic                     cfg_wr;
  logic [CAP_W-1:0]         len_raw;
  logic [LEN_W-1:0]         len;
  logic [PTR_W-1:0]         slot_c;
  logic [SAMPLE_BITS-1:0]   old_sample;
  logic signed [SUM_W-1:0]  old_ext, new_ext;
  logic [SUM_W-1:0]         mag;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [NUM_W-1:0]         div_quot;
  logic [SAMPLE_BITS-1:0]   quot_lo;

  // Window length 2r+1, radius capped at MAX_RADIUS
  always_comb begin
    len_raw = CAP_W'({radius_r, 1'b1});
    if (len_raw > CAP_W'(DEPTH)) begin
      len_raw = CAP_W'(DEPTH);
    end
    len = LEN_W'(len_raw);
  end

  // Ring slot for this sample; a shrunk window restarts at slot 0
  assign slot_c = (LEN_W'(wp_r) >= len) ? '0 : wp_r;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_RADIUS);
  assign cfg_prdata = (cfg_paddr[2] == REG_RADIUS) ? CFG_DATA_W'(radius_r) : '0;

  assign old_ext = {{(SUM_W-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
  assign new_ext = {{(SUM_W-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  // round half away: (2|s| + len) / (2 len)
  assign div_num = {mag, 1'b0} + NUM_W'(len);
  assign div_den = {len, 1'b0};
  assign quot_lo = div_quot[SAMPLE_BITS-1:0];
  assign div_start = (state_r == S_SIGN) && prod_r;

  always_comb begin
    state_nxt     = state_r;
    radius_nxt    = radius_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    slot_nxt      = slot_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          sample_nxt = in_tdata[SAMPLE_BITS-1:0];
          last_nxt   = in_tlast;
          slot_nxt   = slot_c;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        // drop the oldest sample once the window is full
        sum_nxt  = sum_r - ((fill_r >= len) ? old_ext : '0) + new_ext;
        wp_nxt   = (LEN_W'(slot_r) + LEN_W'(1) >= len) ? '0 : slot_r + PTR_W'(1);
        fill_nxt = (fill_r < len) ? fill_r + LEN_W'(1) : fill_r;
        prod_nxt = (fill_nxt >= len);
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        neg_nxt   = sum_r[SUM_W-1];
        state_nxt = prod_r ? S_DIV : S_IDLE;
        if (last_r) begin
          sum_nxt  = '0;
          fill_nxt = '0;
          wp_nxt   = '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = neg_r ? SAMPLE_BITS'(-quot_lo) : quot_lo;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // radius write restarts the set
    if (cfg_wr) begin
      radius_nxt = cfg_pwdata[RADIUS_W-1:0];
      sum_nxt    = '0;
      fill_nxt   = '0;
      wp_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RADIUS_RESET;
      sum_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      prod_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      prod_r      <= prod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    neg_r    <= neg_nxt;
    out_r    <= out_nxt;
  end

  cma_store #(
    .DEPTH  (DEPTH),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (state_r == S_UPD),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (in_accept),
    .rd_addr (slot_c),
    .rd_data (old_sample)
  );

  cma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_r);

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the centered moving average filter.
`timescale 1ns / 1ps
module testbench;
  import cma_pkg::*;

  // Sizes follow the default build of the block.
  localparam int DATA_W        = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int SUM_W         = 21;
  localparam int DEPTH         = 2 * MAX_RADIUS_DEF + 1;
  // Settling wait, longer than a result takes from accept to output.
  localparam int SETTLE_CYCLES = 40;
  localparam int END_WAIT      = 20000;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [CFG_ADDR_W-1:0] RADIUS_ADDR = {REG_RADIUS, 2'b00};
  // Register index 1: nothing lives there, writes must be dropped.
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR  = {~REG_RADIUS, 2'b00};

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  // Flavors of sample content for the random sets.
  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_SMALL, MIX_BITS} sample_mix_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata    = '0;   // [15:0] sample
  logic                  in_tlast    = 1'b0; // last_in_set
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic [DATA_W-1:0]     out_tdata;          // [15:0] average
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  centered_moving_average dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 20 ns period, first rising edge at 10 ns.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Handshake pressure, in percent of cycles.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // Bookkeeping for the summary.
  int          errors     = 0;
  int          samples    = 0;
  int          sets       = 0;
  int          averages   = 0;
  int          reg_writes = 0;
  int          cycles     = 0;
  logic [7:0]  radii_seen = '0;

  // ---------------------------------------------------------------------
  // Filter predictor: own copy of the ring, running sum and radius.
  // ---------------------------------------------------------------------
  sample_t                  win_mem [DEPTH];
  logic signed [SUM_W-1:0]  win_sum  = '0;
  int                       win_fill = 0;
  int                       win_ptr  = 0;
  logic [RADIUS_W-1:0]      cur_radius = RADIUS_RESET;

  // Averages still owed by the block, oldest first.
  sample_t avg_q[$];

  task automatic window_clear();
    win_sum  = '0;
    win_fill = 0;
    win_ptr  = 0;
  endtask

  // Push one accepted word through the predictor; queue its average if the
  // window is full afterwards.
  task automatic window_push(input sample_t s, input logic last);
    int  len;
    int  p;
    int  mag;
    int  q;
    logic neg;
    len = 2 * ((cur_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(cur_radius)) + 1;
    p = (win_ptr >= len) ? 0 : win_ptr;
    // Full window: the oldest sample sits in the slot about to be reused.
    if (win_fill >= len) win_sum -= win_mem[p];
    win_mem[p] = s;
    win_sum += s;
    win_ptr = (p + 1 >= len) ? 0 : p + 1;
    if (win_fill < len) win_fill++;
    if (win_fill >= len) begin
      // Round half away from zero on the magnitude, then restore the sign.
      neg = (win_sum < 0);
      mag = neg ? -int'(win_sum) : int'(win_sum);
      q = (2 * mag + len) / (2 * len);
      avg_q.push_back(sample_t'(neg ? -q : q));
    end
    if (last) window_clear();
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls and the scoreboard check.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rcv_idle_pct == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : avg_check
    sample_t want;
    sample_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[SAMPLE_BITS_DEF-1:0];
      if (avg_q.size() == 0) begin
        $display("%0t: average word with none expected: expected none, actual %0d",
                 $time, got);
        errors++;
      end else begin
        want = avg_q.pop_front();
        averages++;
        if (got !== want) begin
          $display("%0t: average mismatch: expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Hard stop if the block hangs anywhere.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d averages outstanding",
               $time, cycles, avg_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one sample word, with random idle cycles ahead of it. Valid stays
  // high after the accept so back-to-back words need no extra step.
  task automatic send_sample(input sample_t s, input logic last);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'($unsigned(s));
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    window_push(s, last);
    samples++;
    if (last) sets++;
  endtask

  task automatic send_set(input int n, input sample_mix_t mix, input logic close);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_sample(mix), close && (i == n - 1));
    end
  endtask

  // Drop valid, drain the owed averages, then give a sample that produced
  // nothing time to retire before touching the registers.
  task automatic settle();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (avg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    reg_writes++;
    // Only the radius register exists; a radius write also empties the window.
    if (addr == RADIUS_ADDR) begin
      cur_radius = data[RADIUS_W-1:0];
      window_clear();
    end
  endtask

  task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr,
                          output logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_radius();
    logic [CFG_DATA_W-1:0] rd;
    cfg_read(RADIUS_ADDR, rd);
    if (rd !== CFG_DATA_W'(cur_radius)) begin
      $display("%0t: radius readback mismatch: expected %0d, actual %0d",
               $time, cur_radius, rd);
      errors++;
    end
  endtask

  task automatic set_radius(input logic [RADIUS_W-1:0] r);
    settle();
    cfg_write(RADIUS_ADDR, CFG_DATA_W'(r));
    check_radius();
    radii_seen[r] = 1'b1;
  endtask

  function automatic sample_t pick_sample(input sample_mix_t mix);
    sample_t s;
    int      v;
    case (mix)
      MIX_EXTREME: begin
        // Rails and their neighbors
        v = $urandom_range(3);
        s = v[1] ? 16'sh7fff : 16'sh8000;
        if (v[0]) s = v[1] ? sample_t'(s - 1) : sample_t'(s + 1);
      end
      MIX_SMALL: begin
        // Tiny values exercise rounding on both signs
        v = $urandom_range(8);
        s = sample_t'(v - 4);
      end
      MIX_BITS: begin
        s = sample_t'(1) << $urandom_range(SAMPLE_BITS_DEF - 1);
        if ($urandom_range(1)) s = ~s;
      end
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset radius of 1, a set too short for a window, then full-scale values.
  task automatic test_reset_state();
    radii_seen[cur_radius] = 1'b1;
    check_radius();
    send_sample(16'sh1234, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  // Radius zero: each word comes straight back.
  task automatic test_radius_zero();
    set_radius('0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0001, 1'b1);
  endtask

  // Widest window at the negative rail; a write to the unused register in
  // the middle of the set must leave the window alone.
  task automatic test_widest_window();
    set_radius(RADIUS_W'(MAX_RADIUS_DEF));
    for (int i = 0; i < 8; i++) send_sample(16'sh8000, 1'b0);
    settle();
    cfg_write(SPARE_ADDR, $urandom);
    check_radius();
    for (int i = 0; i < 6; i++) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // A radius write mid-set restarts the window; a stale sample would show
  // up as an extra average.
  task automatic test_midset_radius_write();
    set_radius(RADIUS_W'(1));
    send_sample(16'sh7fff, 1'b0);
    set_radius(RADIUS_W'(1));
    send_sample(16'shffff, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0000, 1'b1);
  endtask

  // Mostly sets long enough to fill the window, some short ones, some left
  // open across a radius change, now and then a dropped register write.
  task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n_items);
    int                  blk_items;
    int                  done;
    int                  n;
    int                  win;
    logic [RADIUS_W-1:0] r;
    sample_mix_t         mix;
    logic                close;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    blk_items = n_items / 5;
    for (int blk = 0; blk < 5; blk++) begin
      if (blk == 0) r = RADIUS_W'(MAX_RADIUS_DEF);
      else if (blk == 1) r = '0;
      else r = RADIUS_W'($urandom_range(MAX_RADIUS_DEF));
      set_radius(r);
      win  = 2 * r + 1;
      done = 0;
      while (done < blk_items) begin
        if ($urandom_range(9) < 8) n = $urandom_range(win + 40, win);
        else n = $urandom_range(win, 1);
        // keep the block at its share of the items
        if (n > blk_items - done) n = blk_items - done;
        mix   = sample_mix_t'($urandom_range(3));
        close = (done + n < blk_items) || $urandom_range(1);
        done += n;
        if ($urandom_range(9) == 0) begin
          send_set(n / 2, mix, 1'b0);
          settle();
          cfg_write(SPARE_ADDR, $urandom);
          n = n - n / 2;
        end
        send_set(n, mix, close);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int waited;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_radius_zero();
    test_widest_window();
    test_midset_radius_write();

    test_random_phase(0, 0, 450);
    test_random_phase(48, 0, 450);
    test_random_phase(0, 48, 450);
    test_random_phase(14, 14, 450);

    // Drain: every owed average must turn up, then a quiet tail.
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    waited = 0;
    while (avg_q.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (avg_q.size() != 0) begin
      $display("%0t: %0d averages never arrived, oldest expected %0d",
               $time, avg_q.size(), avg_q[0]);
      errors++;
    end

    $display("Run covered %0d samples in %0d closed sets, %0d averages checked, %0d reg writes",
             samples, sets, averages, reg_writes);
    $display("Radii used (bit per radius): %b, under four source/sink pressure mixes",
             radii_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
